>>> src/salru_pkg.sv
// Shared types and constants for the set-associative LRU tag store.
// Used by salru_ctrl, salru_datapath and set_assoc_cache_lru_lookup_top.
package salru_pkg;

    // Default build geometry
    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 64;

    // Fixed field widths
    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 62;
    localparam int STAMP_W = 64;
    localparam int CNT_W   = 32;

    // Configuration reset values
    localparam logic [3:0] RST_SET_BITS    = 4'd4;
    localparam logic [4:0] RST_OFFSET_BITS = 5'd4;
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;

    // Configuration register word indexes; the byte address is 4 * index.
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

    // Access outcome codes
    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    // One stored line: tag and last-use stamp
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the address and read its set
        logic clr;      // clear one row of valid bits
        logic resolve;  // decide hit, fill or eviction from the set read
        logic scan;     // examine one way for the oldest stamp
        logic evict;    // commit the eviction chosen by the scan
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic need_evict;
        logic scan_last;
    } t_dp_sts;

endpackage

>>> src/salru_ctrl.sv
// Sequencer for the LRU tag store: clearing pass, lookup, LRU scan, eviction.
// Depends on salru_pkg for the command and status structs.
module salru_ctrl import salru_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_EVICT
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_LOOKUP;
                        r_busy  <= 1'b1;
                    end
                end
                S_LOOKUP: begin
                    if (i_sts.need_evict) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (i_sts.scan_last) begin
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_busy  <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.clr     = (r_state == S_CLEAR);
        o_cmd.load    = (r_state == S_IDLE) && i_start;
        o_cmd.resolve = (r_state == S_LOOKUP);
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.evict   = (r_state == S_EVICT);
    end

    assign o_busy = r_busy;

endmodule

>>> src/salru_datapath.sv
// Datapath of the LRU tag store: address decode, set memories, way compare,
// LRU scan, use clock, saturating totals and the result registers.
// Depends on salru_pkg.
module salru_datapath import salru_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [3:0]        i_set_bits,
    input  logic [4:0]        i_offset_bits,
    input  logic [3:0]        i_ways_in_use,
    output logic              o_done,
    output logic [1:0]        o_outcome,
    output logic [7:0]        o_set_number,
    output logic [TAG_W-1:0]  o_line_tag,
    output logic [2:0]        o_way_used,
    output logic [CNT_W-1:0]  o_hit_total,
    output logic [CNT_W-1:0]  o_miss_total,
    output logic [CNT_W-1:0]  o_eviction_total
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_WIDTH >= ADDR_W) ? {ADDR_W{1'b1}}
                               : ((ADDR_W'(1) << ADDR_WIDTH) - ADDR_W'(1));

    // Set memories, one row per set
    logic [MAX_WAYS-1:0]        r_valid_mem [NUM_SETS];
    t_line [MAX_WAYS-1:0]       r_line_mem  [NUM_SETS];
    logic [MAX_WAYS-1:0]        r_rd_valid;
    t_line [MAX_WAYS-1:0]       r_rd_lines;

    // Captured access
    logic [SET_W-1:0]           r_set;
    logic [7:0]                 r_set_num;
    logic [TAG_W-1:0]           r_tag;
    logic [WCNT_W-1:0]          r_ways;

    // Control state
    logic [SET_W-1:0]           r_clr_ptr;
    logic [STAMP_W-1:0]         r_use_clock;
    logic [CNT_W-1:0]           r_hits;
    logic [CNT_W-1:0]           r_misses;
    logic [CNT_W-1:0]           r_evicts;
    logic                       r_done;

    // LRU scan
    logic [WAY_W-1:0]           r_scan_way;
    logic [WAY_W-1:0]           r_best_way;
    logic [STAMP_W-1:0]         r_best_age;

    // Result payload
    t_outcome                   r_outcome;
    logic [7:0]                 r_set_out;
    logic [TAG_W-1:0]           r_tag_out;
    logic [WAY_W-1:0]           r_way_out;

    // Decode
    logic [ADDR_W-1:0]          addr_m;
    logic [4:0]                 sb;
    logic [5:0]                 tag_sh;
    logic [ADDR_W-1:0]          set64;
    logic [ADDR_W-1:0]          tag64;
    logic [7:0]                 ways8;
    logic [WCNT_W-1:0]          ways_eff;

    // Lookup
    logic [MAX_WAYS-1:0]        match;
    logic [MAX_WAYS-1:0]        free;
    logic                       hit_any;
    logic                       free_any;
    logic [WAY_W-1:0]           hit_way;
    logic [WAY_W-1:0]           free_way;
    logic                       need_evict;
    logic [STAMP_W-1:0]         age;

    // Commit
    logic                       commit;
    logic [WAY_W-1:0]           c_way;
    t_outcome                   c_outcome;
    logic [MAX_WAYS-1:0]        new_valid;
    t_line [MAX_WAYS-1:0]       new_lines;
    logic [7:0]                 way8;

    always_comb begin
        addr_m = i_address & ADDR_MASK;
        if ({1'b0, i_set_bits} > 5'(MAX_SET_BITS)) begin
            sb = 5'(MAX_SET_BITS);
        end else begin
            sb = {1'b0, i_set_bits};
        end
        tag_sh = 6'(sb) + 6'(i_offset_bits);
        set64  = (addr_m >> i_offset_bits) & ((ADDR_W'(1) << sb) - ADDR_W'(1));
        tag64  = addr_m >> tag_sh;
        ways8  = {4'b0, i_ways_in_use};
        if (ways8 == 8'd0) begin
            ways_eff = WCNT_W'(1);
        end else if (ways8 > 8'(MAX_WAYS)) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(ways8);
        end
    end

    // Capture the access and read its set in the same edge.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set      <= set64[SET_W-1:0];
            r_set_num  <= set64[7:0];
            r_tag      <= tag64[TAG_W-1:0];
            r_ways     <= ways_eff;
            r_rd_valid <= r_valid_mem[set64[SET_W-1:0]];
            r_rd_lines <= r_line_mem[set64[SET_W-1:0]];
        end
    end

    // Way compare and lowest-numbered selection
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            match[w] = (WCNT_W'(w) < r_ways) && r_rd_valid[w]
                       && (r_rd_lines[w].tag == r_tag);
            free[w]  = (WCNT_W'(w) < r_ways) && !r_rd_valid[w];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (free[w]) begin
                free_way = WAY_W'(w);
            end
        end
        hit_any    = |match;
        free_any   = |free;
        need_evict = !hit_any && !free_any;
        age        = r_use_clock - r_rd_lines[r_scan_way].stamp;
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_clr_ptr == {SET_W{1'b1}});
        o_sts.need_evict = need_evict;
        o_sts.scan_last  = ((WCNT_W'(r_scan_way) + WCNT_W'(1)) == r_ways);
    end

    // Commit of the chosen way
    always_comb begin
        commit = (i_cmd.resolve && !need_evict) || i_cmd.evict;
        if (i_cmd.evict) begin
            c_way     = r_best_way;
            c_outcome = OUT_EVICT;
        end else if (hit_any) begin
            c_way     = hit_way;
            c_outcome = OUT_HIT;
        end else begin
            c_way     = free_way;
            c_outcome = OUT_FILL;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            new_valid[w] = r_rd_valid[w] || (c_way == WAY_W'(w));
        end
        new_lines              = r_rd_lines;
        new_lines[c_way].tag   = r_tag;
        new_lines[c_way].stamp = r_use_clock;
    end

    // Memory writes: the clearing pass touches only the valid bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_valid_mem[r_clr_ptr] <= '0;
        end else if (commit) begin
            r_valid_mem[r_set] <= new_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_line_mem[r_set] <= new_lines;
        end
    end

    // LRU scan: strictly larger age wins, so ties keep the lower way.
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_scan_way <= '0;
            r_best_way <= '0;
            r_best_age <= '0;
        end else if (i_cmd.scan) begin
            r_scan_way <= r_scan_way + WAY_W'(1);
            if (age > r_best_age) begin
                r_best_age <= age;
                r_best_way <= r_scan_way;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr   <= '0;
            r_use_clock <= STAMP_W'(1);
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= commit;
            if (i_cmd.clr) begin
                r_clr_ptr <= r_clr_ptr + SET_W'(1);
            end
            if (commit) begin
                r_use_clock <= r_use_clock + STAMP_W'(1);
                if (c_outcome == OUT_HIT) begin
                    if (r_hits != {CNT_W{1'b1}}) begin
                        r_hits <= r_hits + CNT_W'(1);
                    end
                end else if (r_misses != {CNT_W{1'b1}}) begin
                    r_misses <= r_misses + CNT_W'(1);
                end
                if (c_outcome == OUT_EVICT && r_evicts != {CNT_W{1'b1}}) begin
                    r_evicts <= r_evicts + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_outcome <= c_outcome;
            r_set_out <= r_set_num;
            r_tag_out <= r_tag;
            r_way_out <= c_way;
        end
    end

    assign way8             = 8'(r_way_out);
    assign o_done           = r_done;
    assign o_outcome        = r_outcome;
    assign o_set_number     = r_set_out;
    assign o_line_tag       = r_tag_out;
    assign o_way_used       = way8[2:0];
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;

endmodule

>>> src/set_assoc_cache_lru_lookup_top.sv
// Top level of the set-associative cache tag store with true LRU replacement.
// Instantiates salru_ctrl and salru_datapath; uses salru_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   --------  ---------  ------------------------  --------------------------------------
//   access    in         start high, busy low      i_address
//   result    out        o_done, one cycle only    o_outcome, o_set_number, o_line_tag,
//                                                  o_way_used, o_hit_total, o_miss_total,
//                                                  o_eviction_total
//   config    in/out     APB, pready always high   pwdata / prdata, paddr selects register
//
// After reset the block sweeps the valid-bit memory one set per cycle, so busy
// stays high until all 2**MAX_SET_BITS sets are cleared (256 at the default geometry).
// A hit or a fill into an empty way first captures the address and reads its set,
// then compares all ways in parallel and writes back.
// An eviction adds the LRU scan, which examines one way per cycle through a single
// 64-bit age subtract and compare, and then commits the oldest way.
// The result beat appears in the cycle after the write-back; the receiver cannot
// stall, and the next beat may be accepted in the same cycle as the result.
module set_assoc_cache_lru_lookup_top import salru_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Access channel
    input  logic              start,
    output logic              busy,
    input  logic [ADDR_W-1:0] i_address,
    // Result channel
    output logic              o_done,
    output logic [1:0]        o_outcome,
    output logic [7:0]        o_set_number,
    output logic [TAG_W-1:0]  o_line_tag,
    output logic [2:0]        o_way_used,
    output logic [CNT_W-1:0]  o_hit_total,
    output logic [CNT_W-1:0]  o_miss_total,
    output logic [CNT_W-1:0]  o_eviction_total,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Register word indexes are taken from paddr[3:2].
    logic [3:0] r_set_bits;
    logic [4:0] r_offset_bits;
    logic [3:0] r_ways_in_use;
    logic       cfg_wr;
    t_dp_cmd    dp_cmd;
    t_dp_sts    dp_sts;

    // Configuration registers. The user must write them only while the block is idle;
    // the block does not enforce this. A value takes effect with the next access beat.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= RST_SET_BITS;
            r_offset_bits <= RST_OFFSET_BITS;
            r_ways_in_use <= RST_WAYS_IN_USE;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SET_BITS:    r_set_bits    <= pwdata[3:0];
                REG_OFFSET_BITS: r_offset_bits <= pwdata[4:0];
                REG_WAYS_IN_USE: r_ways_in_use <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SET_BITS:    prdata = {28'b0, r_set_bits};
            REG_OFFSET_BITS: prdata = {27'b0, r_offset_bits};
            REG_WAYS_IN_USE: prdata = {28'b0, r_ways_in_use};
            default:         prdata = '0;
        endcase
    end

    // The controller steps through clear, lookup, scan and eviction; the
    // datapath owns all storage and arithmetic.
    salru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    salru_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_address        (i_address),
        .i_set_bits       (r_set_bits),
        .i_offset_bits    (r_offset_bits),
        .i_ways_in_use    (r_ways_in_use),
        .o_done           (o_done),
        .o_outcome        (o_outcome),
        .o_set_number     (o_set_number),
        .o_line_tag       (o_line_tag),
        .o_way_used       (o_way_used),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    // A result beat only follows a cycle in which an access was in progress.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without an access in progress");

    // An accepted access holds busy high in the following cycle.
    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("access accepted but block not busy");

    // A result carries one of the three defined outcome codes.
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_outcome == OUT_HIT || o_outcome == OUT_FILL
                    || o_outcome == OUT_EVICT))
        else $error("undefined outcome code");

    // An eviction result has already been counted in the eviction total.
    a_evict_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_outcome == OUT_EVICT) |-> (o_eviction_total != '0))
        else $error("eviction reported but not counted");

endmodule
